// ----- rtl/srpg_pkg.sv -----
`timescale 1ns / 1ps

package srpg_pkg;

    localparam int POS_W   = 12;  // servo position
    localparam int TICK_W  = 16;  // elapsed / ramp length
    localparam int DLY_W   = 16;  // power-off delay register
    localparam int CD_W    = 17;  // power-off countdown
    localparam int LVL_W   = 7;   // requested level
    localparam int HELD_W  = 8;   // signed level reports
    localparam int SPAN_W  = 13;  // signed difference of two positions
    localparam int PROD_W  = 30;  // signed span times 17 bit factor
    localparam int NUM_W   = 28;  // dividend magnitude
    localparam int DEN_W   = 16;  // divisor
    localparam int DCNT_W  = 5;   // divider step count
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [LVL_W-1:0]  FULL_LEVEL = 7'd100;
    localparam logic [TICK_W-1:0] PERCENT    = 16'd100;
    localparam logic [TICK_W-1:0] TICK_MAX   = 16'hFFFF;

    localparam logic [POS_W-1:0]  RST_CLOSED = 12'd1000;
    localparam logic [POS_W-1:0]  RST_OPEN   = 12'd1000;
    localparam logic [DLY_W-1:0]  RST_DELAY  = 16'd500;
    localparam logic [POS_W-1:0]  RST_CUR    = 12'd1;
    localparam logic [POS_W-1:0]  RST_TARGET = 12'd1000;
    localparam logic signed [HELD_W-1:0] LVL_UNKNOWN = -8'sd1;
    localparam logic signed [HELD_W-1:0] LVL_POS_MAX = 8'sd127;
    localparam logic signed [HELD_W-1:0] LVL_NEG_MAX = -8'sd128;

    localparam logic [CFG_AW-1:0] REG_CLOSED = 2'd0;
    localparam logic [CFG_AW-1:0] REG_OPEN   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_DELAY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_GO,
        ST_DIV,
        ST_EST,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_TGT,
        OP_POS,
        OP_LVL
    } t_op;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [NUM_W-1:0]   quo;
        logic               rem_nz;
    } t_div_res;

endpackage

// ----- rtl/srpg_div.sv -----
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module srpg_div import srpg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res,
    output logic     o_busy
);

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]    r_quo;
    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;

    logic [DEN_W:0]      w_sh;
    logic [DEN_W+1:0]    w_diff;
    logic                w_fits;

    assign w_sh   = {r_rem, r_quo[NUM_W-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_den};
    assign w_fits = ~w_diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quo    = r_quo;
    assign o_res.rem_nz = |r_rem;
    assign o_busy       = r_busy;

endmodule

// ----- rtl/servo_ramp_power_gate.sv -----
`timescale 1ns / 1ps

// Servo ramp with power timeout. Each input word is a 1 ms tick (tuser 0) or a
// set-level command (tuser 1) and yields exactly one output word with the state
// after it. One 28-step restoring divider, fed by a registered multiplier, does
// the target mapping, the ramp fraction and the level estimate in turn. An item
// makes zero, one or two passes through the multiplier and divider (the target
// mapping or the ramp step, then the level estimate); s_axis_tready is high only
// while the sequencer idles. A finished word waits in the output register while
// the next word is accepted. Configuration writes belong in idle time; new
// endpoints apply to the target from the next set-level command and to the level
// estimate from the next word.
module servo_ramp_power_gate import srpg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_addr,
    input  logic [CFG_DW-1:0]       i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // level[6:0], transition_ms[22:7]
    input  logic                    s_axis_tuser,   // func
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata    // position[11:0], power_on[12],
                                                    // moving[13], commanded_level[21:14],
                                                    // current_level[29:22]
);

    // configuration
    logic [POS_W-1:0]  r_closed, r_open;
    logic [DLY_W-1:0]  r_delay;

    // servo state
    logic [POS_W-1:0]  r_cur, n_cur;
    logic [POS_W-1:0]  r_origin, n_origin;
    logic [POS_W-1:0]  r_target, n_target;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic [TICK_W-1:0] r_ramp, n_ramp;
    logic [CD_W-1:0]   r_countdown, n_countdown;
    logic              r_supply, n_supply;
    logic signed [HELD_W-1:0] r_held, n_held;

    // sequencer and datapath
    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic signed [SPAN_W-1:0] r_ma, n_ma;
    logic [TICK_W-1:0] r_mb, n_mb;
    logic signed [PROD_W-1:0] r_prod;
    logic [DEN_W-1:0]  r_den, n_den;
    logic              r_rsign, n_rsign;
    logic              r_neg, n_neg;
    logic signed [HELD_W-1:0] r_lvl, n_lvl;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    t_div_req          w_div_req;
    t_div_res          w_div_res;
    logic              w_div_busy;

    logic              w_accept;
    logic [LVL_W-1:0]  w_level;
    logic [TICK_W-1:0] w_transition;
    logic              w_same;
    logic              w_full;
    logic [TICK_W-1:0] w_elapsed_inc;
    logic              w_moving;
    logic              w_ramping;
    logic              w_countdown_nz;
    logic [SPAN_W-1:0] w_range;
    logic              w_range_nz;
    logic [PROD_W-1:0] w_prod_abs;
    logic [POS_W-1:0]  w_qf;
    logic [POS_W-1:0]  w_pos_new;
    logic signed [HELD_W-1:0] w_lvl_sat;
    logic              w_out_free;

    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_level       = s_axis_tdata[LVL_W-1:0];
    assign w_transition  = s_axis_tdata[LVL_W+TICK_W-1:LVL_W];
    assign w_same        = (r_held == $signed({1'b0, w_level}));
    assign w_full        = (w_level >= FULL_LEVEL);
    assign w_elapsed_inc = (r_elapsed < TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign w_moving      = (r_cur != r_target);
    assign w_ramping     = (r_ramp != '0) && (w_elapsed_inc < r_ramp);
    assign w_countdown_nz = (r_countdown != '0);
    assign w_range       = {1'b0, r_open} - {1'b0, r_closed};
    assign w_range_nz    = (r_open != r_closed);
    assign w_prod_abs    = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // floor of the signed quotient, low bits only (positions wrap at 12 bits)
    assign w_qf = r_neg ? POS_W'(12'd0 - (w_div_res.quo[POS_W-1:0] + POS_W'(w_div_res.rem_nz)))
                        : w_div_res.quo[POS_W-1:0];
    assign w_pos_new = r_origin + w_qf;

    // truncated quotient saturated to a signed byte
    always_comb begin
        if (r_neg) begin
            w_lvl_sat = (w_div_res.quo > NUM_W'(128)) ? LVL_NEG_MAX
                                                      : $signed(8'd0 - w_div_res.quo[7:0]);
        end else begin
            w_lvl_sat = (w_div_res.quo > NUM_W'(127)) ? LVL_POS_MAX
                                                      : $signed(w_div_res.quo[7:0]);
        end
    end

    assign w_div_req.start = (r_state == ST_GO);
    assign w_div_req.num   = w_prod_abs[NUM_W-1:0];
    assign w_div_req.den   = r_den;

    srpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_res   (w_div_res),
        .o_busy  (w_div_busy)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser) begin
                        n_state = (w_same || w_full) ? ST_EST : ST_MUL;
                    end else begin
                        n_state = (w_moving && w_ramping) ? ST_MUL : ST_EST;
                    end
                end
            end
            ST_MUL: n_state = ST_GO;
            ST_GO:  n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_res.done) begin
                    n_state = (r_op == OP_LVL) ? ST_DONE : ST_EST;
                end
            end
            ST_EST:  n_state = (w_moving && w_range_nz) ? ST_MUL : ST_DONE;
            ST_DONE: n_state = w_out_free ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_cur       = r_cur;
        n_origin    = r_origin;
        n_target    = r_target;
        n_elapsed   = r_elapsed;
        n_ramp      = r_ramp;
        n_countdown = r_countdown;
        n_supply    = r_supply;
        n_held      = r_held;
        n_op        = r_op;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_den       = r_den;
        n_rsign     = r_rsign;
        n_neg       = r_neg;
        n_lvl       = r_lvl;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser) begin
                        if (!w_same) begin
                            n_held      = $signed({1'b0, w_level});
                            n_origin    = r_cur;
                            n_elapsed   = '0;
                            n_ramp      = w_transition;
                            n_countdown = '0;
                            if (w_full) begin
                                n_target = r_open;
                            end else begin
                                n_ma  = $signed(w_range);
                                n_mb  = TICK_W'(w_level);
                                n_den = PERCENT;
                                n_op  = OP_TGT;
                            end
                        end
                    end else begin
                        n_elapsed = w_elapsed_inc;
                        if (w_moving) begin
                            n_supply = 1'b1;
                            if (w_ramping) begin
                                n_ma  = $signed({1'b0, r_target} - {1'b0, r_origin});
                                n_mb  = w_elapsed_inc;
                                n_den = r_ramp;
                                n_op  = OP_POS;
                            end else begin
                                // arrival by jump
                                n_cur       = r_target;
                                n_elapsed   = '0;
                                n_ramp      = '0;
                                n_countdown = {1'b0, r_delay} + 1'b1;
                            end
                        end else if (w_countdown_nz) begin
                            n_countdown = r_countdown - 1'b1;
                            if (r_countdown == CD_W'(1)) begin
                                n_supply = 1'b0;
                            end
                        end
                    end
                end
            end
            ST_GO: begin
                n_neg = r_prod[PROD_W-1] ^ ((r_op == OP_LVL) && r_rsign);
            end
            ST_DIV: begin
                if (w_div_res.done) begin
                    unique case (r_op)
                        OP_TGT: n_target = r_closed + w_qf;
                        OP_POS: begin
                            n_cur = w_pos_new;
                            if (w_pos_new == r_target) begin
                                n_elapsed   = '0;
                                n_ramp      = '0;
                                n_countdown = {1'b0, r_delay} + 1'b1;
                            end
                        end
                        OP_LVL: n_lvl = w_lvl_sat;
                        default: n_lvl = r_lvl;
                    endcase
                end
            end
            ST_EST: begin
                if (w_moving && w_range_nz) begin
                    n_ma    = $signed({1'b0, r_cur} - {1'b0, r_closed});
                    n_mb    = PERCENT;
                    n_den   = DEN_W'(w_range[SPAN_W-1] ? SPAN_W'(-w_range) : w_range);
                    n_rsign = w_range[SPAN_W-1];
                    n_op    = OP_LVL;
                end else begin
                    n_lvl = r_held;
                end
            end
            ST_MUL, ST_DONE: begin
                n_lvl = r_lvl;
            end
            default: begin
                n_lvl = r_lvl;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed    <= RST_CLOSED;
            r_open      <= RST_OPEN;
            r_delay     <= RST_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CLOSED: r_closed <= i_cfg_wdata[POS_W-1:0];
                REG_OPEN:   r_open   <= i_cfg_wdata[POS_W-1:0];
                REG_DELAY:  r_delay  <= i_cfg_wdata[DLY_W-1:0];
                default:    r_delay  <= r_delay;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= RST_CUR;
            r_origin    <= RST_CUR;
            r_target    <= RST_TARGET;
            r_elapsed   <= '0;
            r_ramp      <= '0;
            r_countdown <= '0;
            r_supply    <= 1'b0;
            r_held      <= LVL_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_origin    <= n_origin;
            r_target    <= n_target;
            r_elapsed   <= n_elapsed;
            r_ramp      <= n_ramp;
            r_countdown <= n_countdown;
            r_supply    <= n_supply;
            r_held      <= n_held;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_den   <= n_den;
        r_rsign <= n_rsign;
        r_neg   <= n_neg;
        r_lvl   <= n_lvl;
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_ma * $signed({1'b0, r_mb}));
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= {2'b00, r_lvl, r_held, w_moving, r_supply, r_cur};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !s_axis_tvalid) |=> (r_state == ST_IDLE))
        else $error("sequencer left idle without an input word");

    a_countdown_powered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_countdown != '0) |-> r_supply)
        else $error("power-off pending while supply is already off");

    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_busy)
        else $error("divider restarted while busy");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_res.done |-> (r_state == ST_DIV))
        else $error("divider result arrived outside the divide state");

endmodule
